// ===== sv/ttm_pkg.sv =====
// Package with the shared types, constants and sine function of the two-tone modulator.
package ttm_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int PAIRS_PER_BYTE = 4;
    localparam int OUT_W          = 16;
    localparam int AMP_W          = 15;
    localparam int MAG_W          = SAMPLE_BITS + 1;
    localparam int SUM_W          = MAG_W + 2;
    localparam int ABS_W          = MAG_W + 1;
    localparam int PROD_W         = ABS_W + AMP_W;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_AW        = 2;
    localparam int ADDR_W         = 4;
    localparam int DATA_W         = 32;

    localparam logic [AMP_W-1:0] AMPLITUDE_RESET = 15'd16384;
    localparam logic [31:0]      TONE0_RESET     = 32'd42949673;
    localparam logic [31:0]      TONE1_RESET     = 32'd85899346;
    localparam logic [15:0]      SPS_RESET       = 16'd64;

    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint POLY_A  = 64'sd1686629713;
    localparam longint POLY_B  = 64'sd693598670;
    localparam longint POLY_C  = 64'sd85569306;
    localparam longint POLY_D  = 64'sd4858525;
    localparam longint ROUND_ADD = 64'sd1 << (30 - SAMPLE_BITS);
    localparam longint ROUND_DIV = 64'sd1 << (31 - SAMPLE_BITS);

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_AMPLITUDE          = 2'd0,
        REG_TONE0_STEP         = 2'd1,
        REG_TONE1_STEP         = 2'd2,
        REG_SAMPLES_PER_SYMBOL = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] sample;
        logic                    last_of_byte;
        logic                    underrun;
    } out_item_t;

    typedef struct packed {
        logic [AMP_W-1:0] amplitude;
        logic [31:0]      tone0_step;
        logic [31:0]      tone1_step;
        logic [15:0]      samples_per_symbol;
    } cfg_t;

    typedef struct packed {
        logic [31:0] phase0;
        logic [31:0] phase1;
        logic        key0;
        logic        key1;
        logic        last_of_byte;
        logic        underrun;
    } tick_t;

    // Quarter-wave sine magnitude with SAMPLE_BITS-1 fraction bits, rounded half up.
    function automatic longint sine_mag(input int r, input int addr_bits);
        longint x;
        longint x2;
        longint t;
        longint y;
        x  = longint'(r) * (64'sd1 << (30 - (addr_bits - 2)));
        x2 = (x * x) / Q30_ONE;
        t  = POLY_C - (x2 * POLY_D) / Q30_ONE;
        t  = POLY_B - (x2 * t) / Q30_ONE;
        t  = POLY_A - (x2 * t) / Q30_ONE;
        y  = (x * t) / Q30_ONE;
        y  = (y + ROUND_ADD) / ROUND_DIV;
        return y;
    endfunction

endpackage

// ===== sv/ttm_regs.sv =====
// Configuration register file with its APB-style access port.
module ttm_regs
    import ttm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_AMPLITUDE:          cfg_next.amplitude          = pwdata[AMP_W-1:0];
                REG_TONE0_STEP:         cfg_next.tone0_step         = pwdata;
                REG_TONE1_STEP:         cfg_next.tone1_step         = pwdata;
                REG_SAMPLES_PER_SYMBOL: cfg_next.samples_per_symbol = pwdata[15:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_AMPLITUDE:          prdata = {{(DATA_W-AMP_W){1'b0}}, cfg_reg.amplitude};
            REG_TONE0_STEP:         prdata = cfg_reg.tone0_step;
            REG_TONE1_STEP:         prdata = cfg_reg.tone1_step;
            REG_SAMPLES_PER_SYMBOL: prdata = {16'd0, cfg_reg.samples_per_symbol};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.amplitude          <= AMPLITUDE_RESET;
            cfg_reg.tone0_step         <= TONE0_RESET;
            cfg_reg.tone1_step         <= TONE1_RESET;
            cfg_reg.samples_per_symbol <= SPS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/ttm_front.sv =====
// Front end: accepts items, tracks the held byte and tone phases, and classifies each tick.
module ttm_front
    import ttm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  cfg_t     cfg,
    input  logic     queue_full,
    output logic     push,
    output tick_t    push_item
);

    logic [31:0] phase0_reg;
    logic [31:0] phase0_next;
    logic [31:0] phase1_reg;
    logic [31:0] phase1_next;
    logic [7:0]  held_byte_reg;
    logic [7:0]  held_byte_next;
    logic        byte_valid_reg;
    logic        byte_valid_next;
    logic [1:0]  pair_index_reg;
    logic [1:0]  pair_index_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic        accept;
    logic        is_tick;
    logic [1:0]  pair_bits;
    logic        pair_done;
    logic        byte_done;

    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign is_tick   = (in_item.operation == OP_TICK);
    assign push      = accept && is_tick;
    assign pair_bits = 2'(held_byte_reg >> {pair_index_reg, 1'b0});
    assign pair_done = ({1'b0, count_reg} + 17'd1) >= {1'b0, cfg.samples_per_symbol};
    assign byte_done = pair_done && (pair_index_reg == 2'(PAIRS_PER_BYTE - 1));

    always_comb
    begin
        push_item.phase0       = phase0_reg;
        push_item.phase1       = phase1_reg;
        push_item.key0         = byte_valid_reg && pair_bits[0];
        push_item.key1         = byte_valid_reg && pair_bits[1];
        push_item.last_of_byte = byte_valid_reg && byte_done;
        push_item.underrun     = !byte_valid_reg;
    end

    always_comb
    begin
        phase0_next     = phase0_reg;
        phase1_next     = phase1_reg;
        held_byte_next  = held_byte_reg;
        byte_valid_next = byte_valid_reg;
        pair_index_next = pair_index_reg;
        count_next      = count_reg;
        if (accept)
        begin
            if (!is_tick)
            begin
                held_byte_next  = in_item.data_byte;
                byte_valid_next = 1'b1;
                pair_index_next = '0;
                count_next      = '0;
            end
            else
            begin
                phase0_next = phase0_reg + cfg.tone0_step;
                phase1_next = phase1_reg + cfg.tone1_step;
                if (byte_valid_reg)
                begin
                    if (pair_done)
                    begin
                        count_next = '0;
                        if (byte_done)
                        begin
                            byte_valid_next = 1'b0;
                            pair_index_next = '0;
                        end
                        else
                        begin
                            pair_index_next = pair_index_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        count_next = count_reg + 16'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase0_reg     <= '0;
            phase1_reg     <= '0;
            held_byte_reg  <= '0;
            byte_valid_reg <= 1'b0;
            pair_index_reg <= '0;
            count_reg      <= '0;
        end
        else
        begin
            phase0_reg     <= phase0_next;
            phase1_reg     <= phase1_next;
            held_byte_reg  <= held_byte_next;
            byte_valid_reg <= byte_valid_next;
            pair_index_reg <= pair_index_next;
            count_reg      <= count_next;
        end
    end

endmodule

// ===== sv/ttm_fifo.sv =====
// Short queue of classified ticks between the front end and the sample pipeline.
module ttm_fifo
    import ttm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  tick_t push_item,
    input  logic  pop,
    output tick_t head_item,
    output logic  empty,
    output logic  full
);

    tick_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/ttm_back.sv =====
// Sample pipeline: sine lookup, keyed sum, amplitude scaling and the output register.
module ttm_back
    import ttm_pkg::*;
#(
    parameter int SINE_ADDR_BITS = 10
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  tick_t            head_item,
    output logic             pop,
    input  logic [AMP_W-1:0] amplitude,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_item
);

    localparam int SPAN = 1 << (SINE_ADDR_BITS - 2);
    localparam int R_W  = SINE_ADDR_BITS - 1;
    localparam int Q_W  = SINE_ADDR_BITS - 2;
    localparam logic [OUT_W-1:0] MAX_OUT = {1'b0, {(OUT_W-1){1'b1}}};

    logic [MAG_W-1:0] quarter_tab [SPAN+1];

    for (genvar g = 0; g <= SPAN; g++)
    begin : g_tab
        assign quarter_tab[g] = MAG_W'(sine_mag(g, SINE_ADDR_BITS));
    end

    logic                      en;
    logic [SINE_ADDR_BITS-1:0] addr0;
    logic [SINE_ADDR_BITS-1:0] addr1;
    logic [R_W-1:0]            rr0;
    logic [R_W-1:0]            rr1;

    logic                      v1_reg;
    logic [MAG_W-1:0]          mag0_reg;
    logic [MAG_W-1:0]          mag1_reg;
    logic                      neg0_reg;
    logic                      neg1_reg;
    logic                      key0_reg;
    logic                      key1_reg;
    logic                      last1_reg;
    logic                      under1_reg;

    logic signed [SUM_W-1:0]   s0;
    logic signed [SUM_W-1:0]   s1;
    logic signed [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]          sum_abs;
    logic                      v2_reg;
    logic [ABS_W-1:0]          abs_reg;
    logic                      neg2_reg;
    logic                      last2_reg;
    logic                      under2_reg;

    logic                      v3_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic                      neg3_reg;
    logic                      last3_reg;
    logic                      under3_reg;

    logic [PROD_W-SAMPLE_BITS-1:0] scaled;
    logic [OUT_W-1:0]          sat;
    logic                      out_valid_reg;
    out_item_t                 out_item_reg;
    out_item_t                 out_item_next;

    assign en        = !out_valid_reg || out_ready;
    assign pop       = en && head_valid;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign addr0 = head_item.phase0[31 -: SINE_ADDR_BITS];
    assign addr1 = head_item.phase1[31 -: SINE_ADDR_BITS];
    assign rr0   = addr0[SINE_ADDR_BITS-2] ? R_W'(SPAN) - {1'b0, addr0[Q_W-1:0]}
                                           : {1'b0, addr0[Q_W-1:0]};
    assign rr1   = addr1[SINE_ADDR_BITS-2] ? R_W'(SPAN) - {1'b0, addr1[Q_W-1:0]}
                                           : {1'b0, addr1[Q_W-1:0]};

    always_comb
    begin
        s0 = '0;
        s1 = '0;
        if (key0_reg)
        begin
            s0 = neg0_reg ? -$signed({2'b00, mag0_reg}) : $signed({2'b00, mag0_reg});
        end
        if (key1_reg)
        begin
            s1 = neg1_reg ? -$signed({2'b00, mag1_reg}) : $signed({2'b00, mag1_reg});
        end
        sum     = s0 + s1;
        sum_abs = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    end

    always_comb
    begin
        scaled = prod_reg[PROD_W-1:SAMPLE_BITS];
        sat    = (scaled > (PROD_W-SAMPLE_BITS)'(MAX_OUT)) ? MAX_OUT : scaled[OUT_W-1:0];
        out_item_next.sample       = neg3_reg ? -$signed(sat) : $signed(sat);
        out_item_next.last_of_byte = last3_reg;
        out_item_next.underrun     = under3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag0_reg   <= quarter_tab[rr0];
            mag1_reg   <= quarter_tab[rr1];
            neg0_reg   <= addr0[SINE_ADDR_BITS-1];
            neg1_reg   <= addr1[SINE_ADDR_BITS-1];
            key0_reg   <= head_item.key0;
            key1_reg   <= head_item.key1;
            last1_reg  <= head_item.last_of_byte;
            under1_reg <= head_item.underrun;

            abs_reg    <= sum_abs[ABS_W-1:0];
            neg2_reg   <= sum[SUM_W-1];
            last2_reg  <= last1_reg;
            under2_reg <= under1_reg;

            prod_reg   <= PROD_W'(abs_reg * amplitude);
            neg3_reg   <= neg2_reg;
            last3_reg  <= last2_reg;
            under3_reg <= under2_reg;

            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= pop;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

endmodule

// ===== sv/two_tone_bit_pair_modulator_top.sv =====
// Top level of the two-tone bit-pair on-off keying modulator.
// Usage: items arrive on in_valid/in_ready with an in_item_t payload. A load
// transfer stores a byte that is sent as four bit pairs, lowest pair first; it
// produces no result. A tick transfer produces exactly one result on
// out_valid/out_ready: a signed sample, a flag on the last sample of the byte,
// and an underrun flag when no byte is held.
// Throughput is one item per cycle while the queue is not full. A tick's
// transfer writes its queue entry; the entry then passes through the four
// pipeline registers for the sine lookup, keyed sum, amplitude product and
// output in that order, and the result leaves on out_valid/out_ready.
// The front-end phase accumulators, sample counter and pair index
// feed back on themselves.
// Registers are written through the APB-style port and must change only
// while the block is idle. Reset clears the phases, the held byte, the queue
// and the pipeline, and loads the register defaults.
// When the receiver stalls, the pipeline holds and ticks gather in a
// four-entry queue; in_ready drops once that queue is full.
module two_tone_bit_pair_modulator_top
    import ttm_pkg::*;
#(
    parameter int SINE_ADDR_BITS = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t  cfg;
    logic  queue_full;
    logic  queue_empty;
    logic  push;
    tick_t push_item;
    logic  pop;
    tick_t head_item;

    ttm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ttm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    ttm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    ttm_back #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!queue_empty),
        .head_item  (head_item),
        .pop        (pop),
        .amplitude  (cfg.amplitude),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule
